// File: rtl/msce_pkg.sv
// Shared types, widths and codes for the masked segment centroid extractor.
`default_nettype none

package msce_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int COORD_W     = 6;
    localparam int VALUE_W     = 8;
    localparam int MASK_W      = 8;
    localparam int SUM_W       = 18;
    localparam int OFFS_W      = COORD_W + 1;
    localparam int QUOT_W      = COORD_W;
    localparam int FUNC_W      = 2;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int LIM_W       = 11;

    localparam int X_SIZE_DEF  = 64;
    localparam int Y_SIZE_DEF  = 64;

    localparam logic [MASK_W-1:0]  THR_RESET = 8'd100;
    localparam logic [COUNT_W-1:0] MIN_RESET = 13'd15;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PIXEL  = 2'd0,
        FUNC_FINISH = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASK_THR = 1'b0,
        REG_MIN_PIX  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/msce_store.sv
// Entry store: one write port, one registered read port.
`default_nettype none

module msce_store (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [msce_pkg::ADDR_W-1:0] waddr,
    input  wire msce_pkg::entry_t           wdata,
    input  wire logic                       re,
    input  wire logic [msce_pkg::ADDR_W-1:0] raddr,
    output msce_pkg::entry_t                rdata
);
    import msce_pkg::*;

    entry_t mem [STORE_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/msce_div.sv
// Radix-2 divider for a quotient known to fit in QUOT_W bits.
`default_nettype none

module msce_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [msce_pkg::SUM_W-1:0]   dividend,
    input  wire logic [msce_pkg::COUNT_W-1:0] divisor,
    output logic                             done,
    output logic [msce_pkg::QUOT_W-1:0]      quotient
);
    import msce_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              fits;
    logic [SUM_W-1:0]  rem_sub;

    assign fits    = rem_reg >= dsh_reg;
    assign rem_sub = rem_reg - dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
                rem_reg  <= dividend;
                // divisor aligned to the top quotient bit
                dsh_reg  <= SUM_W'({divisor, {(QUOT_W - 1){1'b0}}});
                quot_reg <= '0;
            end
            else if (run_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_sub;
                end
                quot_reg <= {quot_reg[QUOT_W-2:0], fits};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: rtl/masked_segment_centroid_extract.sv
// Top level of the masked segment centroid extractor.
`default_nettype none

// Masked segment centroid extractor. A request is taken when start is high
// and busy is low; results appear on the output ports, with done high for
// exactly one cycle, and the receiver has no way to hold them off.
// Per request:
//   pixel  (func 0): busy stays low, so pixels stream one per clock.
//   finish (func 1): busy while the two radix-2 dividers (one quotient bit
//                    per clock) run in parallel; done rises in the same
//                    cycle that busy drops.
//   read   (func 2): busy while the entry store read completes; done
//                    rises in the same cycle that busy drops.
//   func 3:          ignored, no result.
// Kept pixels are written to a 4096-entry store in arrival order; the store
// has no reset and needs no clearing pass, since only entries written during
// the current frame can be read back as valid.
// Configuration (cfg_we/cfg_index/cfg_data) may be written any cycle; index 0
// is the mask threshold, index 1 the minimum pixel count.
module masked_segment_centroid_extract #(
    parameter int X_SIZE = msce_pkg::X_SIZE_DEF,
    parameter int Y_SIZE = msce_pkg::Y_SIZE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [msce_pkg::FUNC_W-1:0]   func,
    input  wire logic [msce_pkg::VALUE_W-1:0]  pixel_value,
    input  wire logic [msce_pkg::MASK_W-1:0]   mask_value,
    input  wire logic [msce_pkg::COORD_W-1:0]  x_pos,
    input  wire logic [msce_pkg::COORD_W-1:0]  y_pos,
    input  wire logic [msce_pkg::ADDR_W-1:0]   entry_index,
    input  wire logic                          cfg_we,
    input  wire logic [msce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [msce_pkg::CFG_W-1:0]    cfg_data,
    output logic                               done,
    output logic                               accepted,
    output logic [msce_pkg::COUNT_W-1:0]       pixel_count,
    output logic [msce_pkg::COORD_W-1:0]       centroid_x,
    output logic [msce_pkg::COORD_W-1:0]       centroid_y,
    output logic                               entry_valid,
    output logic [msce_pkg::VALUE_W-1:0]       entry_value,
    output logic signed [msce_pkg::OFFS_W-1:0] offset_x,
    output logic signed [msce_pkg::OFFS_W-1:0] offset_y
);
    import msce_pkg::*;

    localparam logic [LIM_W-1:0] X_LIM = LIM_W'(X_SIZE);
    localparam logic [LIM_W-1:0] Y_LIM = LIM_W'(Y_SIZE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ
    } state_t;

    state_t             state_reg;

    // configuration
    logic [MASK_W-1:0]  thr_reg;
    logic [COUNT_W-1:0] min_reg;

    // frame state
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [COORD_W-1:0] centre_x_reg;
    logic [COORD_W-1:0] centre_y_reg;
    logic               seg_ok_reg;
    logic               frame_closed_reg;
    logic               rd_ok_reg;

    // registered results
    logic               done_reg;
    logic               accepted_reg;
    logic [COUNT_W-1:0] pixel_count_reg;
    logic [COORD_W-1:0] centroid_x_reg;
    logic [COORD_W-1:0] centroid_y_reg;
    logic               entry_valid_reg;
    logic [VALUE_W-1:0] entry_value_reg;
    logic [OFFS_W-1:0]  offset_x_reg;
    logic [OFFS_W-1:0]  offset_y_reg;

    logic               accept;
    func_t              func_code;
    logic [COUNT_W-1:0] cnt_base;
    logic [SUM_W-1:0]   sum_x_base;
    logic [SUM_W-1:0]   sum_y_base;
    logic               keep;
    logic               pix_write;
    logic [COUNT_W-1:0] count_next;
    logic [SUM_W-1:0]   sum_x_next;
    logic [SUM_W-1:0]   sum_y_next;
    logic               rd_en;
    logic               rd_ok;
    logic               div_start;
    logic               div_done_x;
    logic               div_done_y;
    logic [QUOT_W-1:0]  quot_x;
    logic [QUOT_W-1:0]  quot_y;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic [OFFS_W-1:0]  offs_x;
    logic [OFFS_W-1:0]  offs_y;

    assign accept    = start && (state_reg == ST_IDLE);
    assign func_code = func_t'(func);

    // a pixel arriving after a finish starts a fresh frame
    assign cnt_base   = frame_closed_reg ? '0 : count_reg;
    assign sum_x_base = frame_closed_reg ? '0 : sum_x_reg;
    assign sum_y_base = frame_closed_reg ? '0 : sum_y_reg;

    assign keep = (mask_value > thr_reg)
               && (LIM_W'(x_pos) < X_LIM)
               && (LIM_W'(y_pos) < Y_LIM)
               && !cnt_base[COUNT_W-1];   // store full at 4096

    assign pix_write  = accept && (func_code == FUNC_PIXEL) && keep;
    assign count_next = keep ? cnt_base + COUNT_W'(1) : cnt_base;
    assign sum_x_next = keep ? sum_x_base + SUM_W'(x_pos) : sum_x_base;
    assign sum_y_next = keep ? sum_y_base + SUM_W'(y_pos) : sum_y_base;

    assign wr_entry.value = pixel_value;
    assign wr_entry.x     = x_pos;
    assign wr_entry.y     = y_pos;

    assign rd_en = accept && (func_code == FUNC_READ);
    assign rd_ok = frame_closed_reg && seg_ok_reg
                && (COUNT_W'(entry_index) < count_reg);

    assign div_start = accept && (func_code == FUNC_FINISH);

    // offsets wrap to 7 bits, two's complement
    assign offs_x = OFFS_W'(rd_entry.x) - OFFS_W'(centre_x_reg);
    assign offs_y = OFFS_W'(rd_entry.y) - OFFS_W'(centre_y_reg);

    msce_store u_store (
        .clk   (clk),
        .we    (pix_write),
        .waddr (cnt_base[ADDR_W-1:0]),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (entry_index),
        .rdata (rd_entry)
    );

    msce_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_x_reg),
        .divisor  (count_reg),
        .done     (div_done_x),
        .quotient (quot_x)
    );

    msce_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_y_reg),
        .divisor  (count_reg),
        .done     (div_done_y),
        .quotient (quot_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            thr_reg          <= THR_RESET;
            min_reg          <= MIN_RESET;
            count_reg        <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            centre_x_reg     <= '0;
            centre_y_reg     <= '0;
            seg_ok_reg       <= 1'b0;
            frame_closed_reg <= 1'b1;
            rd_ok_reg        <= 1'b0;
            done_reg         <= 1'b0;
            accepted_reg     <= 1'b0;
            pixel_count_reg  <= '0;
            centroid_x_reg   <= '0;
            centroid_y_reg   <= '0;
            entry_valid_reg  <= 1'b0;
            entry_value_reg  <= '0;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MASK_THR: thr_reg <= cfg_data[MASK_W-1:0];
                    REG_MIN_PIX:  min_reg <= cfg_data[COUNT_W-1:0];
                    default:      thr_reg <= thr_reg;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (func_code)
                            FUNC_PIXEL:
                            begin
                                if (frame_closed_reg)
                                begin
                                    seg_ok_reg <= 1'b0;
                                end
                                frame_closed_reg <= 1'b0;
                                count_reg        <= count_next;
                                sum_x_reg        <= sum_x_next;
                                sum_y_reg        <= sum_y_next;
                            end
                            FUNC_FINISH:
                            begin
                                seg_ok_reg       <= count_reg > min_reg;
                                frame_closed_reg <= 1'b1;
                                state_reg        <= ST_DIV;
                            end
                            FUNC_READ:
                            begin
                                rd_ok_reg <= rd_ok;
                                state_reg <= ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_DIV:
                begin
                    if (div_done_x && div_done_y)
                    begin
                        // empty segment reports centroid zero
                        centre_x_reg    <= (count_reg == '0) ? '0 : quot_x;
                        centre_y_reg    <= (count_reg == '0) ? '0 : quot_y;
                        centroid_x_reg  <= (count_reg == '0) ? '0 : quot_x;
                        centroid_y_reg  <= (count_reg == '0) ? '0 : quot_y;
                        accepted_reg    <= seg_ok_reg;
                        pixel_count_reg <= count_reg;
                        entry_valid_reg <= 1'b0;
                        entry_value_reg <= '0;
                        offset_x_reg    <= '0;
                        offset_y_reg    <= '0;
                        done_reg        <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                ST_READ:
                begin
                    accepted_reg    <= 1'b0;
                    pixel_count_reg <= '0;
                    centroid_x_reg  <= '0;
                    centroid_y_reg  <= '0;
                    entry_valid_reg <= rd_ok_reg;
                    entry_value_reg <= rd_ok_reg ? rd_entry.value : '0;
                    offset_x_reg    <= rd_ok_reg ? offs_x : '0;
                    offset_y_reg    <= rd_ok_reg ? offs_y : '0;
                    done_reg        <= 1'b1;
                    state_reg       <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign accepted    = accepted_reg;
    assign pixel_count = pixel_count_reg;
    assign centroid_x  = centroid_x_reg;
    assign centroid_y  = centroid_y_reg;
    assign entry_valid = entry_valid_reg;
    assign entry_value = entry_value_reg;
    assign offset_x    = $signed(offset_x_reg);
    assign offset_y    = $signed(offset_y_reg);

endmodule

`default_nettype wire
